@@ rtl/core/lzwc_pkg.sv @@
package lzwc_pkg;

  localparam int unsigned DICT_ENTRIES  = 4096;
  localparam int unsigned MAX_CODE_BITS = 12;
  localparam int unsigned CODE_W        = 12;
  localparam int unsigned WIDTH_W       = 4;
  localparam int unsigned NFC_W         = 13;
  localparam int unsigned KEY_W         = CODE_W + 8;
  localparam int unsigned HASH_W        = 13;
  localparam int unsigned HASH_DEPTH    = 1 << HASH_W;

  localparam logic [NFC_W-1:0]   FIRST_FREE  = NFC_W'(256);
  localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);
  localparam logic [NFC_W-1:0]   CODE_LIMIT  = NFC_W'(DICT_ENTRIES);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  // entry memory word: the key and the hash slot that points back at it
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] slot;
  } entry_t;

  function automatic logic [HASH_W-1:0] hash_key(input logic [CODE_W-1:0] prefix,
                                                 input logic [7:0] data);
    hash_key = HASH_W'({data, 5'b0}) ^ HASH_W'(prefix);
  endfunction

endpackage

@@ rtl/core/lzwc_front.sv @@
module lzwc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_stream_i,
  output logic           item_valid_o,
  output lzwc_pkg::item_t item_o,
  input  logic           item_pop_i
);

  lzwc_pkg::item_t buf_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push;

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(item_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{data_byte: data_byte_i, end_of_stream: end_of_stream_i};
    end
  end

endmodule

@@ rtl/core/lzwc_back.sv @@
module lzwc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  lzwc_pkg::item_t                item_i,
  output logic                           item_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lzwc_pkg::CODE_W-1:0]    code_value_o,
  output logic [lzwc_pkg::WIDTH_W-1:0]   code_width_o,
  output logic                           last_code_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_H, S_RD_E, S_CHECK, S_EMIT_MISS, S_EMIT_FLUSH
  } state_e;

  state_e                          state_q;
  logic [7:0]                      byte_q;
  logic                            eos_q;
  logic [lzwc_pkg::CODE_W-1:0]     prefix_q;
  logic                            pvalid_q;
  logic [lzwc_pkg::NFC_W-1:0]      nfc_q;
  logic [lzwc_pkg::WIDTH_W-1:0]    width_q;
  logic [lzwc_pkg::HASH_W-1:0]     slot_q;
  logic [lzwc_pkg::CODE_W-1:0]     miss_code_q;
  logic [lzwc_pkg::WIDTH_W-1:0]    miss_width_q;
  logic                            out_valid_q;
  logic [lzwc_pkg::CODE_W-1:0]     out_code_q;
  logic [lzwc_pkg::WIDTH_W-1:0]    out_width_q;
  logic                            out_last_q;
  logic                            clr_q;
  logic [lzwc_pkg::HASH_W-1:0]     clr_idx_q;

  logic [lzwc_pkg::CODE_W-1:0]     hmem [lzwc_pkg::HASH_DEPTH];
  lzwc_pkg::entry_t                emem [lzwc_pkg::DICT_ENTRIES];
  logic [lzwc_pkg::CODE_W-1:0]     hdata_q;
  lzwc_pkg::entry_t                edata_q;
  logic                            in_range_q;

  logic                            out_free;
  logic                            take;
  logic                            emit;
  logic                            slot_live;
  logic                            hit;
  logic                            do_insert;
  logic [lzwc_pkg::NFC_W-1:0]      nfc_inc;
  logic [lzwc_pkg::KEY_W-1:0]      key;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign take       = (state_q == S_IDLE) && item_valid_i && !clr_q;
  assign item_pop_o = take;
  assign emit       = out_free && ((state_q == S_EMIT_MISS) || (state_q == S_EMIT_FLUSH));
  assign key        = {prefix_q, byte_q};
  // a slot counts only if its code was issued in this stream and points back here
  assign slot_live  = in_range_q && (edata_q.slot == slot_q);
  assign hit        = slot_live && (edata_q.key == key);
  assign do_insert  = (state_q == S_CHECK) && !slot_live && (nfc_q < lzwc_pkg::CODE_LIMIT);
  assign nfc_inc    = do_insert ? nfc_q + lzwc_pkg::NFC_W'(1) : nfc_q;

  assign out_valid_o  = out_valid_q;
  assign code_value_o = out_code_q;
  assign code_width_o = out_width_q;
  assign last_code_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_H) hdata_q <= hmem[slot_q];
    if (state_q == S_RD_E) edata_q <= emem[hdata_q];
    // zeroed slots point at a single-byte code, which never counts as live
    if (clr_q) begin
      hmem[clr_idx_q] <= '0;
    end else if (do_insert) begin
      hmem[slot_q] <= nfc_q[lzwc_pkg::CODE_W-1:0];
    end
    if (do_insert) begin
      emem[nfc_q[lzwc_pkg::CODE_W-1:0]] <= '{key: key, slot: slot_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_q       <= '0;
      eos_q        <= 1'b0;
      prefix_q     <= '0;
      pvalid_q     <= 1'b0;
      nfc_q        <= lzwc_pkg::FIRST_FREE;
      width_q      <= lzwc_pkg::START_WIDTH;
      slot_q       <= '0;
      miss_code_q  <= '0;
      miss_width_q <= '0;
      in_range_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_code_q   <= '0;
      out_width_q  <= '0;
      out_last_q   <= 1'b0;
      clr_q        <= 1'b1;
      clr_idx_q    <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + lzwc_pkg::HASH_W'(1);
        if (&clr_idx_q) clr_q <= 1'b0;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            byte_q <= item_i.data_byte;
            eos_q  <= item_i.end_of_stream;
            if (!pvalid_q) begin
              prefix_q <= lzwc_pkg::CODE_W'(item_i.data_byte);
              pvalid_q <= 1'b1;
              state_q  <= item_i.end_of_stream ? S_EMIT_FLUSH : S_IDLE;
            end else begin
              slot_q  <= lzwc_pkg::hash_key(prefix_q, item_i.data_byte);
              state_q <= S_RD_H;
            end
          end
        end
        S_RD_H: state_q <= S_RD_E;
        S_RD_E: begin
          in_range_q <= ({1'b0, hdata_q} >= lzwc_pkg::FIRST_FREE) &&
                        ({1'b0, hdata_q} < nfc_q);
          state_q    <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            prefix_q <= edata_q.key == key ? hdata_q : prefix_q;
            state_q  <= eos_q ? S_EMIT_FLUSH : S_IDLE;
          end else if (slot_live) begin
            // occupied by another key: linear probe
            slot_q  <= slot_q + lzwc_pkg::HASH_W'(1);
            state_q <= S_RD_H;
          end else begin
            miss_code_q  <= prefix_q;
            miss_width_q <= width_q;
            nfc_q        <= nfc_inc;
            if (width_q < lzwc_pkg::MAX_WIDTH &&
                nfc_inc == (lzwc_pkg::NFC_W'(1) << width_q)) begin
              width_q <= width_q + lzwc_pkg::WIDTH_W'(1);
            end
            prefix_q <= lzwc_pkg::CODE_W'(byte_q);
            state_q  <= S_EMIT_MISS;
          end
        end
        S_EMIT_MISS: begin
          if (out_free) begin
            out_code_q  <= miss_code_q;
            out_width_q <= miss_width_q;
            out_last_q  <= 1'b0;
            state_q     <= eos_q ? S_EMIT_FLUSH : S_IDLE;
          end
        end
        S_EMIT_FLUSH: begin
          if (out_free) begin
            out_code_q  <= prefix_q;
            out_width_q <= width_q;
            out_last_q  <= 1'b1;
            prefix_q    <= '0;
            pvalid_q    <= 1'b0;
            nfc_q       <= lzwc_pkg::FIRST_FREE;
            width_q     <= lzwc_pkg::START_WIDTH;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/lzw_compressor_unit.sv @@
// lzw compressor: one byte per input beat, one code per output beat
// input channel: in_valid_i / in_stall_o carry data_byte_i and end_of_stream_i
// output channel: out_valid_o / out_stall_i carry code_value_o, code_width_o
// (9 to 12) and last_code_o, which marks the flushed code ending a stream
// a byte with end_of_stream set may produce two beats: the pending code, then
// the flush; the dictionary and code width restart for the following byte
// a two-beat input queue decouples the channel from the dictionary engine
// each lookup probes a hash table then the entry memory; a probe passes through the
// states S_RD_H, S_RD_E and S_CHECK (two synchronous memory reads and a compare);
// a byte is dispatched in S_IDLE, and each emitted code passes through S_EMIT_MISS or S_EMIT_FLUSH;
// collisions add further probes; the hash table is at most half full
// reset clears the queue, the engine and the output register, then the engine
// zeroes all 8192 hash table slots before it takes the first byte;
// stale entries of earlier streams are rejected by a code range and back-pointer check
// while out_stall_i is high the output beat holds, the engine waits and the
// input queue fills, then in_stall_o rises
module lzw_compressor_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_stream_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lzwc_pkg::CODE_W-1:0]  code_value_o,
  output logic [lzwc_pkg::WIDTH_W-1:0] code_width_o,
  output logic                         last_code_o
);

  logic            item_valid;
  lzwc_pkg::item_t item;
  logic            item_pop;

  lzwc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  lzwc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_value_o (code_value_o),
    .code_width_o (code_width_o),
    .last_code_o  (last_code_o)
  );

endmodule

@@ rtl/core/lzwc_checker.sv @@
module lzwc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [lzwc_pkg::CODE_W-1:0]  code_value_o,
  input logic [lzwc_pkg::WIDTH_W-1:0] code_width_o,
  input logic                         last_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_value_o) &&
    $stable(code_width_o) && $stable(last_code_o))
    else $error("output beat changed under stall");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_width_o >= lzwc_pkg::START_WIDTH &&
    code_width_o <= lzwc_pkg::MAX_WIDTH)
    else $error("code width out of range");

  a_code_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_value_o >> code_width_o) == '0)
    else $error("code wider than its width");

  a_width_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_code_o ##1 out_valid_o && !last_code_o
    |-> code_width_o == lzwc_pkg::START_WIDTH || code_value_o < lzwc_pkg::CODE_W'(256))
    else $error("width did not restart after stream end");

endmodule

bind lzw_compressor_unit lzwc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_value_o (code_value_o),
  .code_width_o (code_width_o),
  .last_code_o  (last_code_o)
);

@@ bench/tb_top.sv @@
module tb_top;

  typedef struct {
    logic [lzwc_pkg::CODE_W-1:0]  code;
    logic [lzwc_pkg::WIDTH_W-1:0] width;
    logic                         last;
  } code_beat_t;

  typedef struct {
    logic [7:0]                   data;
    logic                         eos;
    logic                         fixed;
    logic [lzwc_pkg::CODE_W-1:0]  code;
    logic [lzwc_pkg::WIDTH_W-1:0] width;
  } stim_row_t;

  localparam int STALL_LIMIT = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic end_of_stream_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [lzwc_pkg::CODE_W-1:0] code_value_o;
  logic [lzwc_pkg::WIDTH_W-1:0] code_width_o;
  logic last_code_o;

  lzw_compressor_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [lzwc_pkg::KEY_W-1:0]   dict_key [lzwc_pkg::DICT_ENTRIES];
  logic [lzwc_pkg::CODE_W-1:0]  cur_prefix;
  logic                         have_prefix;
  int unsigned                  free_code;
  logic [lzwc_pkg::WIDTH_W-1:0] cur_width;

  code_beat_t pending_codes[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  hold_req = 0;
  int  hold_done = 0;
  logic sending_done = 1'b0;

  function automatic void restart_stream();
    cur_prefix = '0;
    have_prefix = 1'b0;
    free_code = lzwc_pkg::FIRST_FREE;
    cur_width = lzwc_pkg::START_WIDTH;
  endfunction

  function automatic void emit_code(logic [lzwc_pkg::CODE_W-1:0] c, logic lst);
    code_beat_t b;
    b.code = c;
    b.width = cur_width;
    b.last = lst;
    pending_codes.push_back(b);
  endfunction

  function automatic void compress_byte(logic [7:0] d, logic eos);
    int hit;
    hit = -1;
    if (!have_prefix) begin
      cur_prefix = lzwc_pkg::CODE_W'(d);
      have_prefix = 1'b1;
    end else begin
      for (int k = lzwc_pkg::FIRST_FREE; k < free_code; k++)
        if (dict_key[k] == {cur_prefix, d}) begin
          hit = k;
          break;
        end
      if (hit >= 0) begin
        cur_prefix = hit[lzwc_pkg::CODE_W-1:0];
      end else begin
        emit_code(cur_prefix, 1'b0);
        if (free_code < lzwc_pkg::DICT_ENTRIES &&
            free_code < (1 << lzwc_pkg::MAX_CODE_BITS)) begin
          dict_key[free_code] = {cur_prefix, d};
          free_code++;
        end
        if (cur_width < lzwc_pkg::MAX_WIDTH && free_code == (1 << cur_width))
          cur_width++;
        cur_prefix = lzwc_pkg::CODE_W'(d);
      end
    end
    if (eos) begin
      emit_code(cur_prefix, 1'b1);
      restart_stream();
    end
  endfunction

  // sender
  int unsigned fill_left = 0;
  int unsigned sent = 0;

  task automatic send_byte(logic [7:0] d, logic eos);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (fill_left > 0) gap = 0;
    // valid stays high only when the next beat follows at once
    if (gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compress_byte(d, eos);
    sent++;
    if (fill_left > 0) fill_left--;
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // random stream with repeats so the dictionary finds matches
  task automatic send_stream(int len, int alpha);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++)
      send_byte((alpha == 256) ? 8'($urandom_range(0, 255))
                               : 8'(base + $urandom_range(0, alpha - 1)),
                i == len - 1);
  endtask

  stim_row_t rows[$];

  initial begin
    stim_row_t r;
    restart_stream();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: single byte streams with known flush, extremes, two-beat eos
    rows = '{
      '{8'h00, 1'b1, 1'b1, 12'h000, 4'd9},
      '{8'hFF, 1'b1, 1'b1, 12'h0FF, 4'd9},
      '{8'hA5, 1'b1, 1'b1, 12'h0A5, 4'd9},
      '{8'h5A, 1'b1, 1'b1, 12'h05A, 4'd9},
      '{8'h41, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h42, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h41, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h42, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h41, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h42, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h41, 1'b1, 1'b0, 12'h0, 4'd0},
      '{8'h00, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h00, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h00, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'hFF, 1'b1, 1'b0, 12'h0, 4'd0},
      '{8'h7E, 1'b0, 1'b0, 12'h0, 4'd0},
      '{8'h81, 1'b1, 1'b0, 12'h0, 4'd0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_byte(r.data, r.eos);
      if (r.fixed) begin
        // flush of a one-byte stream is the byte itself at start width
        code_beat_t b;
        b = pending_codes[pending_codes.size() - 1];
        if (b.code != r.code || b.width != r.width || b.last !== 1'b1) begin
          $display("%0t directed row %0d: expected %h/%0d got %h/%0d", $time, i,
                   r.code, r.width, b.code, b.width);
          errors++;
        end
      end
    end
    drain_all();

    // long hold-off on the receiver while sender keeps going
    hold_req++;
    fill_left = 12;
    send_stream(12, 4);
    drain_all();

    // a random stream that takes the code width past 9, then a 3-symbol stream with many matches
    send_stream(700, 256);
    send_stream(600, 3);
    drain_all();

    while (sent < 1900) begin
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1: send_stream($urandom_range(1, 3), 256);
        default: send_stream($urandom_range(4, 60), $urandom_range(1, 8));
      endcase
    end
    drain_all();
    sending_done <= 1'b1;
  end

  // receiver
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
        hold_done = hold_req;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    code_beat_t b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        $display("%0t unexpected code beat: expected none, got %h", $time, code_value_o);
        errors++;
      end else begin
        b = pending_codes.pop_front();
        if (code_value_o !== b.code || code_width_o !== b.width ||
            last_code_o !== b.last)
          begin
          $display("%0t code mismatch: expected %h w%0d l%0d, got %h w%0d l%0d",
                   $time, b.code, b.width, b.last, code_value_o, code_width_o,
                   last_code_o);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** lzw_compressor_unit: FAILED **");
      $finish;
    end else if (sending_done) begin
      if (errors == 0 && pending_codes.size() == 0)
        $display("** lzw_compressor_unit: PASSED **");
      else
        $display("** lzw_compressor_unit: FAILED **");
      $finish;
    end
  end
endmodule
